[rtl/mac_pkg.sv]
// Shared types, codes and constants of the meter autorange controller.
package mac_pkg;

  localparam int NUM_RANGES = 5;

  localparam int ACTION_W = 2;
  localparam int BUTTONS  = 3;
  localparam int MODE_W   = 2;
  localparam int RANGE_W  = 3;
  localparam int FREQ_W   = 23;
  localparam int VOLT_W   = 13;
  localparam int OHM_W    = 20;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 23;
  localparam int LIMITS   = 4;

  localparam logic [RANGE_W-1:0] TOP_CAP = RANGE_W'(NUM_RANGES - 1);

  localparam logic [ACTION_W-1:0] ACT_BUTTON   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_AUTO     = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_OVERFLOW = 2'd2;

  localparam logic [MODE_W-1:0] MODE_FREQ = 2'd0;
  localparam logic [MODE_W-1:0] MODE_VOLT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RES  = 2'd2;

  localparam logic [1:0] DB_IDLE       = 2'd0;
  localparam logic [1:0] DB_MAYBE_PUSH = 2'd1;
  localparam logic [1:0] DB_PUSH       = 2'd2;
  localparam logic [1:0] DB_MAYBE_REL  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_TOP_RANGE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_ONE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_TWO   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_THREE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_FOUR  = 3'd4;

  localparam logic [RANGE_W-1:0] TOP_RANGE_RST   = 3'd4;
  localparam logic [FREQ_W-1:0]  LIMIT_ONE_RST   = 23'd500;
  localparam logic [FREQ_W-1:0]  LIMIT_TWO_RST   = 23'd62;
  localparam logic [FREQ_W-1:0]  LIMIT_THREE_RST = 23'd8;
  localparam logic [FREQ_W-1:0]  LIMIT_FOUR_RST  = 23'd2;

  localparam logic [VOLT_W-1:0] VOLT_SWITCH_MV = 13'd800;
  localparam logic [OHM_W-1:0]  RES_UP_OHM     = 20'd8000;
  localparam logic [OHM_W-1:0]  RES_DOWN_OHM   = 20'd6000;

  typedef struct packed {
    logic [RANGE_W-1:0]             top_range;
    logic [LIMITS-1:0][FREQ_W-1:0]  down_limit;
  } cfg_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [BUTTONS-1:0]  button_levels;
    logic [FREQ_W-1:0]   frequency_hz;
    logic [VOLT_W-1:0]   voltage_mv;
    logic [OHM_W-1:0]    resistance_ohm;
  } item_t;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [RANGE_W-1:0] range_index;
    logic               vref_high;
    logic               rref_high;
    logic               autorange_on;
    logic               range_changed;
    logic               mode_changed;
  } result_t;

endpackage

[rtl/mac_debounce.sv]
// Four-phase button debouncer that flags a completed release.
module mac_debounce (
  input  logic clk,
  input  logic rst_n,
  input  logic step_en,
  input  logic pressed,
  output logic released
);
  import mac_pkg::*;

  logic [1:0] phase_r;
  logic [1:0] phase_nxt;

  always_comb begin
    phase_nxt = phase_r;
    released  = 1'b0;
    case (phase_r)
      DB_IDLE:       phase_nxt = pressed ? DB_MAYBE_PUSH : DB_IDLE;
      DB_MAYBE_PUSH: phase_nxt = pressed ? DB_PUSH : DB_IDLE;
      DB_PUSH:       phase_nxt = pressed ? DB_PUSH : DB_MAYBE_REL;
      default: begin
        if (pressed) begin
          phase_nxt = DB_PUSH;
        end else begin
          phase_nxt = DB_IDLE;
          released  = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= DB_IDLE;
    end else if (step_en) begin
      phase_r <= phase_nxt;
    end
  end

endmodule

[rtl/mac_range_core.sv]
// Meter state: button handling, manual stepping and autorange decisions.
module mac_range_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step_en,
  input  mac_pkg::item_t   item,
  input  mac_pkg::cfg_t    cfg,
  output mac_pkg::result_t res
);
  import mac_pkg::*;

  logic [MODE_W-1:0]  mode_r,  mode_nxt;
  logic [RANGE_W-1:0] range_r, range_nxt;
  logic               vref_r,  vref_nxt;
  logic               rref_r,  rref_nxt;
  logic               auto_r,  auto_nxt;
  logic               ovf_r,   ovf_nxt;
  logic               rchg, mchg;
  logic [BUTTONS-1:0] rel;
  logic [BUTTONS-1:0] db_en;
  logic [RANGE_W-1:0] top;
  logic [FREQ_W-1:0]  limit;

  assign db_en = {BUTTONS{step_en && item.action == ACT_BUTTON}};

  for (genvar i = 0; i < BUTTONS; i++) begin : g_db
    mac_debounce u_db (
      .clk      (clk),
      .rst_n    (rst_n),
      .step_en  (db_en[i]),
      .pressed  (item.button_levels[i]),
      .released (rel[i])
    );
  end

  assign top = (cfg.top_range < TOP_CAP) ? cfg.top_range : TOP_CAP;

  always_comb begin
    case (range_r)
      3'd1:    limit = cfg.down_limit[0];
      3'd2:    limit = cfg.down_limit[1];
      3'd3:    limit = cfg.down_limit[2];
      default: limit = cfg.down_limit[3];
    endcase
  end

  always_comb begin
    mode_nxt  = mode_r;
    range_nxt = range_r;
    vref_nxt  = vref_r;
    rref_nxt  = rref_r;
    auto_nxt  = auto_r;
    ovf_nxt   = ovf_r;
    rchg      = 1'b0;
    mchg      = 1'b0;
    case (item.action)
      ACT_BUTTON: begin
        if (rel[0]) begin
          mode_nxt = (mode_r < MODE_RES) ? mode_r + 2'd1 : MODE_FREQ;
          if (mode_nxt == MODE_RES) begin
            vref_nxt = 1'b1;
          end
          auto_nxt = 1'b1;
          mchg     = 1'b1;
          rchg     = 1'b1;
        end
        if (rel[1]) begin
          auto_nxt = ~auto_nxt;
          rchg     = 1'b1;
        end
        if (rel[2] && !auto_r) begin
          case (mode_nxt)
            MODE_FREQ: range_nxt = (range_r < top) ? range_r + 3'd1 : 3'd0;
            MODE_VOLT: vref_nxt  = ~vref_nxt;
            MODE_RES:  rref_nxt  = ~rref_r;
            default:   range_nxt = range_r;
          endcase
          rchg = 1'b1;
        end
      end
      ACT_AUTO: begin
        if (auto_r) begin
          case (mode_r)
            MODE_FREQ: begin
              if (ovf_r) begin
                if (range_r < top) begin
                  range_nxt = range_r + 3'd1;
                  rchg      = 1'b1;
                end
                ovf_nxt = 1'b0;
              end else if (range_r != 3'd0 && item.frequency_hz > limit) begin
                range_nxt = range_r - 3'd1;
                rchg      = 1'b1;
              end
            end
            MODE_VOLT: begin
              vref_nxt = item.voltage_mv > VOLT_SWITCH_MV;
              rchg     = vref_nxt != vref_r;
            end
            MODE_RES: begin
              if (item.resistance_ohm > RES_UP_OHM && !rref_r) begin
                rref_nxt = 1'b1;
                rchg     = 1'b1;
              end else if (item.resistance_ohm < RES_DOWN_OHM && rref_r) begin
                rref_nxt = 1'b0;
                rchg     = 1'b1;
              end
            end
            default: rchg = 1'b0;
          endcase
        end
      end
      ACT_OVERFLOW: ovf_nxt = 1'b1;
      default:      ovf_nxt = ovf_r;
    endcase
  end

  assign res = '{mode: mode_nxt, range_index: range_nxt, vref_high: vref_nxt,
                 rref_high: rref_nxt, autorange_on: auto_nxt,
                 range_changed: rchg, mode_changed: mchg};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_FREQ;
      range_r <= '0;
      vref_r  <= 1'b1;
      rref_r  <= 1'b0;
      auto_r  <= 1'b1;
      ovf_r   <= 1'b0;
    end else if (step_en) begin
      mode_r  <= mode_nxt;
      range_r <= range_nxt;
      vref_r  <= vref_nxt;
      rref_r  <= rref_nxt;
      auto_r  <= auto_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

endmodule

[rtl/meter_autorange_controller.sv]
// Top level of the meter autorange controller: input register, core, result register.
// Throughput: one item per cycle while out_ready is high. The state update sits between the
// input register and the result register, which raises out_valid when an item moves into it.
// Reset (rst_n low, synchronous): frequency mode, range 0, 5.0 V and 1 kohm references,
// autoranging on, debouncers idle, no overflow pending, configuration at defaults.
module meter_autorange_controller (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [mac_pkg::ACTION_W-1:0]   in_action,
  input  logic [mac_pkg::BUTTONS-1:0]    in_button_levels,
  input  logic [mac_pkg::FREQ_W-1:0]     in_frequency_hz,
  input  logic [mac_pkg::VOLT_W-1:0]     in_voltage_mv,
  input  logic [mac_pkg::OHM_W-1:0]      in_resistance_ohm,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [mac_pkg::MODE_W-1:0]     out_mode,
  output logic [mac_pkg::RANGE_W-1:0]    out_range_index,
  output logic                           out_vref_high,
  output logic                           out_rref_high,
  output logic                           out_autorange_on,
  output logic                           out_range_changed,
  output logic                           out_mode_changed,
  input  logic                           cfg_wr_en,
  input  logic [mac_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mac_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mac_pkg::*;

  item_t   item_r;
  logic    in_valid_r;
  result_t res;
  result_t res_r;
  logic    out_valid_r;
  cfg_t    cfg_r;
  logic    advance;

  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= '{action: in_action, button_levels: in_button_levels,
                  frequency_hz: in_frequency_hz, voltage_mv: in_voltage_mv,
                  resistance_ohm: in_resistance_ohm};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  mac_range_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .item    (item_r),
    .cfg     (cfg_r),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.top_range     <= TOP_RANGE_RST;
      cfg_r.down_limit[0] <= LIMIT_ONE_RST;
      cfg_r.down_limit[1] <= LIMIT_TWO_RST;
      cfg_r.down_limit[2] <= LIMIT_THREE_RST;
      cfg_r.down_limit[3] <= LIMIT_FOUR_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_TOP_RANGE:   cfg_r.top_range     <= cfg_data[RANGE_W-1:0];
        CFG_LIMIT_ONE:   cfg_r.down_limit[0] <= cfg_data[FREQ_W-1:0];
        CFG_LIMIT_TWO:   cfg_r.down_limit[1] <= cfg_data[FREQ_W-1:0];
        CFG_LIMIT_THREE: cfg_r.down_limit[2] <= cfg_data[FREQ_W-1:0];
        CFG_LIMIT_FOUR:  cfg_r.down_limit[3] <= cfg_data[FREQ_W-1:0];
        default:         cfg_r.top_range     <= cfg_r.top_range;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_mode          = res_r.mode;
  assign out_range_index   = res_r.range_index;
  assign out_vref_high     = res_r.vref_high;
  assign out_rref_high     = res_r.rref_high;
  assign out_autorange_on  = res_r.autorange_on;
  assign out_range_changed = res_r.range_changed;
  assign out_mode_changed  = res_r.mode_changed;

endmodule
